@@ rtl/core/jts_pkg.sv @@
// Types, codes and character helpers for the JSON token scanner.
// No dependencies; every other file in rtl/core imports this package.
package jts_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } scan_in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [2:0]  error_code;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [23:0] line_number;
        logic        last_of_run;
    } token_t;

    // Tokens produced by one accepted beat, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_WORD
    } scan_mode_t;

    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COLON    = 4'd4;
    localparam logic [3:0] KIND_COMMA    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_TRUE     = 4'd8;
    localparam logic [3:0] KIND_FALSE    = 4'd9;
    localparam logic [3:0] KIND_ERROR    = 4'd10;
    localparam logic [3:0] KIND_END      = 4'd11;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_ESCAPE     = 3'd1;
    localparam logic [2:0] ERR_UNFINISHED = 3'd2;
    localparam logic [2:0] ERR_NUMBER     = 3'd3;
    localparam logic [2:0] ERR_WORD       = 3'd4;
    localparam logic [2:0] ERR_SYMBOL     = 3'd5;

    // Keyword match progress: 1..4 prefix of true, 5..9 prefix of false
    localparam logic [4:0] WM_CLEAR = 5'd0;
    localparam logic [4:0] WM_T     = 5'd1;
    localparam logic [4:0] WM_TR    = 5'd2;
    localparam logic [4:0] WM_TRU   = 5'd3;
    localparam logic [4:0] WM_TRUE  = 5'd4;
    localparam logic [4:0] WM_F     = 5'd5;
    localparam logic [4:0] WM_FA    = 5'd6;
    localparam logic [4:0] WM_FAL   = 5'd7;
    localparam logic [4:0] WM_FALS  = 5'd8;
    localparam logic [4:0] WM_FALSE = 5'd9;
    localparam logic [4:0] WM_NONE  = 5'd31;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_E     = 8'h65;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_L     = 8'h6C;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_S     = 8'h73;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_U     = 8'h75;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_VT);
    endfunction

    function automatic logic is_escape(input logic [7:0] b);
        return (b == CH_QUOTE) || (b == CH_BACKSLASH) || (b == CH_LOW_F) ||
               (b == CH_LOW_B) || (b == CH_LOW_N) || (b == CH_LOW_R) || (b == CH_LOW_T);
    endfunction

    function automatic logic [4:0] next_match(input logic [4:0] m, input logic [7:0] b);
        logic [4:0] r;
        r = WM_NONE;
        case (m)
            WM_T:    if (b == CH_LOW_R) r = WM_TR;
            WM_TR:   if (b == CH_LOW_U) r = WM_TRU;
            WM_TRU:  if (b == CH_LOW_E) r = WM_TRUE;
            WM_F:    if (b == CH_LOW_A) r = WM_FA;
            WM_FA:   if (b == CH_LOW_L) r = WM_FAL;
            WM_FAL:  if (b == CH_LOW_S) r = WM_FALS;
            WM_FALS: if (b == CH_LOW_E) r = WM_FALSE;
            default: r = WM_NONE;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/jts_scan.sv @@
// Input register, scanner state and the per-byte lexing logic.
// Depends on jts_pkg; feeds jts_outq with up to two tokens per beat.
module jts_scan #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jts_pkg::scan_in_t s_data,
    input  logic              room,
    output jts_pkg::push_t    push
);
    import jts_pkg::*;

    localparam int OW  = OFFSET_BITS;
    localparam int LW  = LINE_BITS;
    localparam int DW  = (OW + 1 > 17) ? OW + 1 : 17;
    localparam int XW  = (OW > 32) ? OW : 32;
    localparam int LXW = (LW > 24) ? LW : 24;
    localparam logic [OW-1:0] OFF_MAX  = '1;
    localparam logic [LW-1:0] LINE_MAX = '1;

    scan_in_t   item_reg;
    logic       item_valid_reg;
    scan_mode_t mode_reg, mode_next;
    logic [OW-1:0] pos_reg, pos_next;
    logic [OW-1:0] start_reg, start_next;
    logic [LW-1:0] line_reg, line_next;
    logic [4:0]    match_reg, match_next;

    logic          fire;
    logic [7:0]    b;
    logic [OW-1:0] pos_prev;
    logic [15:0]   len_now;
    logic [15:0]   len_str;
    logic [23:0]   line_out;
    logic [LXW-1:0] line_ext;
    logic          idle_scan;
    logic          a_v, b_v;
    token_t        a_tok, b_tok, word_tok;

    function automatic logic [15:0] tok_len(input logic [DW-1:0] end_pos,
                                            input logic [DW-1:0] start_pos);
        logic [DW-1:0] diff;
        diff = end_pos - start_pos;
        if (end_pos < start_pos) return '0;
        if (diff > DW'(LEN_MAX)) return LEN_MAX;
        return diff[15:0];
    endfunction

    function automatic token_t make_tok(input logic [3:0] kind, input logic [2:0] err,
                                        input logic [OW-1:0] off, input logic [15:0] len,
                                        input logic [23:0] line);
        token_t t;
        logic [XW-1:0] ox;
        ox = XW'(off);
        t.token_kind   = kind;
        t.error_code   = err;
        t.start_offset = ox[31:0];
        t.token_length = len;
        t.line_number  = line;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    assign fire    = item_valid_reg && room;
    assign s_ready = !item_valid_reg || room;
    assign b       = item_reg.text_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            mode_reg       <= MODE_IDLE;
            pos_reg        <= '0;
            start_reg      <= '0;
            line_reg       <= LW'(1);
            match_reg      <= WM_CLEAR;
        end else begin
            if (s_ready) begin
                item_valid_reg <= s_valid;
                if (s_valid) item_reg <= s_data;
            end
            if (fire) begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                line_reg  <= line_next;
                match_reg <= match_next;
            end
        end
    end

    always_comb begin
        pos_prev = (pos_reg != '0) ? pos_reg - OW'(1) : '0;
        len_now  = tok_len(DW'(pos_reg), DW'(start_reg));
        len_str  = tok_len(DW'(pos_reg) + DW'(1), DW'(start_reg));
        line_ext = LXW'(line_reg);
        line_out = line_ext[23:0];

        case (match_reg)
            WM_TRUE:  word_tok = make_tok(KIND_TRUE, ERR_NONE, start_reg, len_now, line_out);
            WM_FALSE: word_tok = make_tok(KIND_FALSE, ERR_NONE, start_reg, len_now, line_out);
            default:  word_tok = make_tok(KIND_ERROR, ERR_WORD, start_reg, '0, line_out);
        endcase

        mode_next  = mode_reg;
        pos_next   = (pos_reg != OFF_MAX) ? pos_reg + OW'(1) : pos_reg;
        start_next = start_reg;
        line_next  = line_reg;
        match_next = match_reg;
        idle_scan  = 1'b0;
        a_v        = 1'b0;
        a_tok      = make_tok(KIND_ERROR, ERR_NONE, pos_reg, '0, line_out);
        b_v        = 1'b0;
        b_tok      = make_tok(KIND_END, ERR_NONE, pos_reg, '0, line_out);

        if (item_reg.end_of_text) begin
            // flush the open token, then the end token, then back to reset state
            case (mode_reg)
                MODE_STR, MODE_ESC: begin
                    a_v   = 1'b1;
                    a_tok = make_tok(KIND_ERROR, ERR_UNFINISHED, pos_prev, '0, line_out);
                end
                MODE_INT, MODE_FRAC: begin
                    a_v   = 1'b1;
                    a_tok = make_tok(KIND_NUMBER, ERR_NONE, start_reg, len_now, line_out);
                end
                MODE_DOT: begin
                    a_v   = 1'b1;
                    a_tok = make_tok(KIND_ERROR, ERR_NUMBER, pos_prev, '0, line_out);
                end
                MODE_WORD: begin
                    a_v   = 1'b1;
                    a_tok = word_tok;
                end
                default: a_v = 1'b0;
            endcase
            b_v        = 1'b1;
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            line_next  = LW'(1);
            match_next = WM_CLEAR;
        end else begin
            case (mode_reg)
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        a_v       = 1'b1;
                        a_tok     = make_tok(KIND_STRING, ERR_NONE, start_reg, len_str,
                                             line_out);
                        mode_next = MODE_IDLE;
                    end else if (b == CH_LF) begin
                        a_v       = 1'b1;
                        a_tok     = make_tok(KIND_ERROR, ERR_UNFINISHED, pos_reg, '0,
                                             line_out);
                        mode_next = MODE_IDLE;
                    end else if (b == CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    if (is_escape(b)) begin
                        mode_next = MODE_STR;
                    end else begin
                        a_v       = 1'b1;
                        a_tok     = make_tok(KIND_ERROR, ERR_ESCAPE, pos_reg, '0, line_out);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_INT: begin
                    if (b == CH_DOT) begin
                        mode_next = MODE_DOT;
                    end else if (!is_digit(b)) begin
                        a_v       = 1'b1;
                        a_tok     = make_tok(KIND_NUMBER, ERR_NONE, start_reg, len_now,
                                             line_out);
                        idle_scan = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (is_digit(b)) begin
                        mode_next = MODE_FRAC;
                    end else begin
                        a_v       = 1'b1;
                        a_tok     = make_tok(KIND_ERROR, ERR_NUMBER, pos_prev, '0, line_out);
                        idle_scan = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (!is_digit(b)) begin
                        a_v = 1'b1;
                        if (b == CH_DOT) begin
                            a_tok = make_tok(KIND_ERROR, ERR_NUMBER, pos_reg, '0, line_out);
                        end else begin
                            a_tok = make_tok(KIND_NUMBER, ERR_NONE, start_reg, len_now,
                                             line_out);
                        end
                        idle_scan = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(b)) begin
                        match_next = next_match(match_reg, b);
                    end else begin
                        a_v        = 1'b1;
                        a_tok      = word_tok;
                        match_next = WM_CLEAR;
                        idle_scan  = 1'b1;
                    end
                end
                default: idle_scan = 1'b1;
            endcase

            if (idle_scan) begin
                mode_next = MODE_IDLE;
                if (b == CH_LF) begin
                    line_next = (line_reg != LINE_MAX) ? line_reg + LW'(1) : line_reg;
                end else if (!is_blank(b)) begin
                    start_next = pos_reg;
                    case (b)
                        CH_LBRACE: begin
                            b_v   = 1'b1;
                            b_tok = make_tok(KIND_LBRACE, ERR_NONE, pos_reg, 16'd1, line_out);
                        end
                        CH_RBRACE: begin
                            b_v   = 1'b1;
                            b_tok = make_tok(KIND_RBRACE, ERR_NONE, pos_reg, 16'd1, line_out);
                        end
                        CH_LBRACKET: begin
                            b_v   = 1'b1;
                            b_tok = make_tok(KIND_LBRACKET, ERR_NONE, pos_reg, 16'd1,
                                             line_out);
                        end
                        CH_RBRACKET: begin
                            b_v   = 1'b1;
                            b_tok = make_tok(KIND_RBRACKET, ERR_NONE, pos_reg, 16'd1,
                                             line_out);
                        end
                        CH_COLON: begin
                            b_v   = 1'b1;
                            b_tok = make_tok(KIND_COLON, ERR_NONE, pos_reg, 16'd1, line_out);
                        end
                        CH_COMMA: begin
                            b_v   = 1'b1;
                            b_tok = make_tok(KIND_COMMA, ERR_NONE, pos_reg, 16'd1, line_out);
                        end
                        default: begin
                            if (b == CH_QUOTE) begin
                                mode_next = MODE_STR;
                            end else if (is_digit(b) || (b == CH_MINUS)) begin
                                mode_next = MODE_INT;
                            end else if (is_alpha(b)) begin
                                mode_next  = MODE_WORD;
                                match_next = (b == CH_LOW_T) ? WM_T :
                                             (b == CH_LOW_F) ? WM_F : WM_NONE;
                            end else begin
                                b_v   = 1'b1;
                                b_tok = make_tok(KIND_ERROR, ERR_SYMBOL, pos_reg, '0,
                                                 line_out);
                            end
                        end
                    endcase
                end
            end
        end

        // pack: the later token goes second, last_of_run marks the final one
        push.first  = a_v ? a_tok : b_tok;
        push.second = b_tok;
        if (a_v && b_v) begin
            push.second.last_of_run = 1'b1;
        end else begin
            push.first.last_of_run = 1'b1;
        end
        push.count = fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    end

endmodule

@@ rtl/core/jts_outq.sv @@
// Small token queue that takes up to two tokens a beat and gives one.
// Depends on jts_pkg; sits between jts_scan and the result channel.
module jts_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  jts_pkg::push_t  push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output jts_pkg::token_t m_data
);
    import jts_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          pop;

    assign m_valid = (fill_reg != '0);
    assign m_data  = slot_reg[rd_reg];
    assign pop     = m_valid && m_ready;
    // leave space for a two-token beat
    assign room    = (fill_reg <= CW'(QUEUE_DEPTH - 2));

    always_comb begin
        wr_next   = wr_reg + PW'(push.count);
        rd_next   = rd_reg + PW'(pop);
        fill_next = fill_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) slot_reg[wr_reg] <= push.first;
        if (push.count == 2'd2) slot_reg[wr_reg + PW'(1)] <= push.second;
    end

endmodule

@@ rtl/core/json_token_scanner.sv @@
// Top level of the streaming JSON token scanner.
// Depends on jts_pkg, jts_scan and jts_outq.
//
//   channel  | direction | payload            | beat
//   s_       | in        | scan_in_t (9 bits) | one text byte or an end-of-text mark
//   m_       | out       | token_t (80 bits)  | one token, error or end record
//
// Cycles: one text byte a cycle sustained while each beat yields at most one token and m_ready stays high.
//   A byte is held in the input register, is lexed in a single pass against
//   the scanner state, and its tokens land in a four-entry queue; the first token is
//   valid on m_ once it is written into the queue, and is taken while m_ready is high.
// A beat that yields two tokens gives them on m_ one after the other; the
//   queue takes new work while it has space for two tokens.
// Reset: aresetn clears scanner state, input and queue occupancy.
// Stalls: m_ready low fills the queue, then s_ready drops; nothing is dropped.
module json_token_scanner #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jts_pkg::scan_in_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jts_pkg::token_t   m_data
);
    import jts_pkg::*;

    // tokens produced by the scanner this cycle, and whether the queue can take them
    push_t push;
    logic  room;

    // lex each byte: hold it in the input register, advance the state when the queue has space
    jts_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .room    (room),
        .push    (push)
    );

    // decouple the result side: the queue absorbs two-token beats and downstream stalls
    jts_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
